// ===== rtl/ffsa_pkg.sv =====
// Shared types, codes and sizes of the first-fit segment allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffsa_pkg;
  localparam int DESC_COUNT = 16;
  localparam int IDX_W      = $clog2(DESC_COUNT);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ENTRY_W    = 34;

  localparam logic [1:0] KIND_UNUSED = 2'd0;
  localparam logic [1:0] KIND_FREE   = 2'd1;
  localparam logic [1:0] KIND_ALLOC  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_NO_DESC = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [7:0] CFG_REGION_BASE = 8'd0;
  localparam logic [7:0] CFG_REGION_SIZE = 8'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] offset;
    logic [15:0] length;
  } entry_t;

  typedef struct packed {
    logic [31:0] base;
    logic [15:0] size;
    logic        reinit;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [15:0] size;
    logic [31:0] addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
  } res_t;
endpackage
`default_nettype wire

// ===== rtl/ffsa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ffsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wen,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/ffsa_ctrl.sv =====
// Request sequencer: scans the descriptor RAM, then writes back the updated entries.
`timescale 1ns / 1ps
`default_nettype none
module ffsa_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ffsa_pkg::cfg_t  cfg,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire ffsa_pkg::req_t  req,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output ffsa_pkg::res_t       res
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN1 = 3'd1;
  localparam logic [2:0] S_SCAN2 = 3'd2;
  localparam logic [2:0] S_WR1   = 3'd3;
  localparam logic [2:0] S_WR2   = 3'd4;
  localparam logic [2:0] S_WR3   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] st;
  logic [ffsa_pkg::CNT_W-1:0] cnt;
  logic rvalid_q, vld_q;
  logic [ffsa_pkg::IDX_W-1:0] ridx_q;
  logic [ffsa_pkg::DESC_COUNT-1:0] vld;

  logic        op_q;
  logic [15:0] size_q;
  logic [31:0] addr_q;

  logic spare_f, best_f, hit_f, f_f, p_f;
  logic [ffsa_pkg::IDX_W-1:0] spare_idx, best_idx, hit_idx, f_idx, p_idx;
  logic [15:0] best_off, best_len, hit_start, hit_len, f_len, p_off, p_len;

  logic [1:0]  res_status;
  logic [31:0] res_addr;

  logic [ffsa_pkg::ENTRY_W-1:0] rd_data;
  ffsa_pkg::entry_t raw, eff, wentry;
  logic wen;
  logic [ffsa_pkg::IDX_W-1:0] waddr;
  logic scanning, issue, scan_end;
  logic [16:0] hit_end, eff_end;
  logic [15:0] rest, merged;

  ffsa_ram #(.WIDTH(ffsa_pkg::ENTRY_W), .DEPTH(ffsa_pkg::DESC_COUNT)) u_ram (
    .clk   (clk),
    .wen   (wen),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (cnt[ffsa_pkg::IDX_W-1:0]),
    .rdata (rd_data)
  );

  assign scanning = (st == S_SCAN1) || (st == S_SCAN2);
  assign issue    = scanning && (cnt < ffsa_pkg::CNT_W'(ffsa_pkg::DESC_COUNT));
  assign scan_end = scanning && !issue && !rvalid_q;
  assign hit_end  = {1'b0, hit_start} + {1'b0, hit_len};
  assign eff_end  = {1'b0, eff.offset} + {1'b0, eff.length};
  assign rest     = best_len - size_q;
  assign merged   = hit_len + (f_f ? f_len : 16'd0);

  // Entries never written since init read as the init image.
  always_comb begin
    raw = ffsa_pkg::entry_t'(rd_data);
    if (vld_q) begin
      eff = raw;
    end else if (ridx_q == '0 && cfg.size != 16'd0) begin
      eff = '{kind: ffsa_pkg::KIND_FREE, offset: 16'd0, length: cfg.size};
    end else begin
      eff = '0;
    end
  end

  always_comb begin
    wen    = 1'b0;
    waddr  = hit_idx;
    wentry = '0;
    if (op_q == ffsa_pkg::OP_ALLOC) begin
      case (st)
        S_WR1: begin
          wen    = 1'b1;
          waddr  = best_idx;
          wentry = '{kind: ffsa_pkg::KIND_ALLOC, offset: best_off, length: size_q};
        end
        S_WR2: begin
          wen    = (rest != 16'd0);
          waddr  = spare_idx;
          wentry = '{kind: ffsa_pkg::KIND_FREE, offset: best_off + size_q, length: rest};
        end
        default: wen = 1'b0;
      endcase
    end else begin
      case (st)
        S_WR1: begin
          wen = 1'b1;
          if (p_f) begin
            waddr  = p_idx;
            wentry = '{kind: ffsa_pkg::KIND_FREE, offset: p_off, length: p_len + merged};
          end else begin
            waddr  = hit_idx;
            wentry = '{kind: ffsa_pkg::KIND_FREE, offset: hit_start, length: merged};
          end
        end
        S_WR2: begin
          wen   = p_f;
          waddr = hit_idx;
        end
        S_WR3: begin
          wen   = f_f;
          waddr = f_idx;
        end
        default: wen = 1'b0;
      endcase
    end
  end

  assign req_ready = (st == S_IDLE);
  assign res_valid = (st == S_DONE);
  assign res       = '{status: res_status, addr: res_addr};

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      cnt      <= '0;
      rvalid_q <= 1'b0;
      vld      <= '0;
    end else begin
      if (cfg.reinit) begin
        vld <= '0;
      end else if (wen) begin
        vld[waddr] <= 1'b1;
      end
      rvalid_q <= issue;
      if (issue) begin
        cnt <= cnt + 1'b1;
      end
      case (st)
        S_IDLE: begin
          if (req_valid) begin
            cnt <= '0;
            if (req.op == ffsa_pkg::OP_ALLOC && req.size == 16'd0) begin
              st <= S_DONE;
            end else begin
              st <= S_SCAN1;
            end
          end
        end
        S_SCAN1: begin
          if (scan_end) begin
            if (op_q == ffsa_pkg::OP_ALLOC) begin
              st <= (spare_f && best_f) ? S_WR1 : S_DONE;
            end else if (hit_f) begin
              cnt <= '0;
              st  <= S_SCAN2;
            end else begin
              st <= S_DONE;
            end
          end
        end
        S_SCAN2: if (scan_end) st <= S_WR1;
        S_WR1:   st <= S_WR2;
        S_WR2:   st <= S_WR3;
        S_WR3:   st <= S_DONE;
        S_DONE:  if (res_ready) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

  // Datapath: request capture, scan bookkeeping and result.
  always_ff @(posedge clk) begin
    ridx_q <= cnt[ffsa_pkg::IDX_W-1:0];
    vld_q  <= vld[cnt[ffsa_pkg::IDX_W-1:0]];
    if (st == S_IDLE && req_valid) begin
      op_q       <= req.op;
      size_q     <= req.size;
      addr_q     <= req.addr;
      spare_f    <= 1'b0;
      best_f     <= 1'b0;
      hit_f      <= 1'b0;
      f_f        <= 1'b0;
      p_f        <= 1'b0;
      res_status <= ffsa_pkg::ST_BAD;
      res_addr   <= 32'd0;
    end
    if (st == S_SCAN1 && rvalid_q) begin
      if (op_q == ffsa_pkg::OP_ALLOC) begin
        if (eff.kind == ffsa_pkg::KIND_UNUSED && !spare_f) begin
          spare_f   <= 1'b1;
          spare_idx <= ridx_q;
        end
        if (eff.kind == ffsa_pkg::KIND_FREE && eff.length >= size_q &&
            (!best_f || eff.offset < best_off)) begin
          best_f   <= 1'b1;
          best_idx <= ridx_q;
          best_off <= eff.offset;
          best_len <= eff.length;
        end
      end else if (!hit_f && eff.kind == ffsa_pkg::KIND_ALLOC &&
                   (cfg.base + {16'd0, eff.offset}) == addr_q) begin
        hit_f     <= 1'b1;
        hit_idx   <= ridx_q;
        hit_start <= eff.offset;
        hit_len   <= eff.length;
      end
    end
    // The following neighbor can never also be the preceding one, so one pass finds both.
    if (st == S_SCAN2 && rvalid_q && ridx_q != hit_idx && eff.kind == ffsa_pkg::KIND_FREE) begin
      if (!f_f && {1'b0, eff.offset} == hit_end) begin
        f_f   <= 1'b1;
        f_idx <= ridx_q;
        f_len <= eff.length;
      end
      if (!p_f && eff_end == {1'b0, hit_start}) begin
        p_f   <= 1'b1;
        p_idx <= ridx_q;
        p_off <= eff.offset;
        p_len <= eff.length;
      end
    end
    if (st == S_SCAN1 && scan_end) begin
      if (op_q == ffsa_pkg::OP_ALLOC) begin
        if (!spare_f) begin
          res_status <= ffsa_pkg::ST_NO_DESC;
        end else if (!best_f) begin
          res_status <= ffsa_pkg::ST_NO_FIT;
        end else begin
          res_status <= ffsa_pkg::ST_OK;
          res_addr   <= cfg.base + {16'd0, best_off};
        end
      end else if (hit_f) begin
        res_status <= ffsa_pkg::ST_OK;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_wen_in_wb: assert property (@(posedge clk) disable iff (rst)
    wen |-> (st == S_WR1 || st == S_WR2 || st == S_WR3))
    else $error("table write outside write-back");
  a_req_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (st != S_IDLE))
    else $error("accepted request left sequencer idle");
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> (st == S_IDLE))
    else $error("result taken but sequencer not idle");
  a_no_read_in_wb: assert property (@(posedge clk) disable iff (rst)
    wen |-> !rvalid_q)
    else $error("write-back overlaps scan read");
`endif
endmodule
`default_nettype wire

// ===== rtl/first_fit_segment_allocator.sv =====
// Top level of the first-fit segment allocator: config registers and result register.
// Usage:
//  Requests enter on s_axis: tuser holds the operation (allocate or release),
//  tdata holds request size and release address. Each request gives one result
//  on m_axis: tuser holds the status, tdata the block address (zero on failure
//  or release). cfg writes region_base (index 0) or region_size (index 1); either
//  write reinitializes the table to one free segment covering the region.
//  Write config only while no request is in flight.
// Sequence (16 descriptors here): a zero-size allocate goes straight to the result;
//  an allocate makes one pass over the descriptor RAM at one entry a cycle, plus
//  write-back; a release makes a match pass, then a neighbor pass and write-back.
//  One request is processed at a time; the RAM read port sets the pass length.
// Reset: synchronous rst restores region_base 0, region_size 1024 and the init
//  table at once; no clearing pass is needed.
// Stall: a finished result waits in the output register; the next request is
//  accepted and processed meanwhile, and only its own result waits for m_axis.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_segment_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // request_size[15:0], release_address[47:16]
  input  wire logic [0:0]  s_axis_tuser,   // operation[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // block_address[31:0]
  output logic      [1:0]  m_axis_tuser,   // status[1:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic [31:0] region_base;
  logic [15:0] region_size;
  ffsa_pkg::cfg_t cfg;
  ffsa_pkg::req_t req;
  ffsa_pkg::res_t res;
  logic res_valid, res_ready;

  assign cfg_ready = 1'b1;
  assign cfg.base  = region_base;
  assign cfg.size  = region_size;
  assign cfg.reinit = cfg_valid &&
      (cfg_index == ffsa_pkg::CFG_REGION_BASE || cfg_index == ffsa_pkg::CFG_REGION_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= 32'd0;
      region_size <= 16'd1024;
    end else if (cfg_valid) begin
      if (cfg_index == ffsa_pkg::CFG_REGION_BASE) begin
        region_base <= cfg_data;
      end else if (cfg_index == ffsa_pkg::CFG_REGION_SIZE) begin
        region_size <= cfg_data[15:0];
      end
    end
  end

  assign req.op   = s_axis_tuser[0];
  assign req.size = s_axis_tdata[15:0];
  assign req.addr = s_axis_tdata[47:16];

  ffsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_axis_tdata <= res.addr;
      m_axis_tuser <= res.status;
    end
  end
endmodule
`default_nettype wire

// ===== bench/first_fit_segment_allocator_test.sv =====
// Self-checking bench for the first-fit segment allocator: random requests against a predictor.
`timescale 1ns / 1ps
module first_fit_segment_allocator_test;
  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // request_size[15:0], release_address[47:16]
  logic [0:0]  s_axis_tuser;   // operation[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // block_address[31:0]
  logic [1:0]  m_axis_tuser;   // status[1:0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_data;

  first_fit_segment_allocator DUT (.*);

  // pending requests, expected results
  ffsa_pkg::req_t   req_q[$];
  ffsa_pkg::res_t   result_q[$];
  // predictor state
  ffsa_pkg::entry_t seg_tab[ffsa_pkg::DESC_COUNT];
  logic [31:0] pred_base;
  logic [15:0] pred_size;
  // addresses handed out so far, used to aim releases
  logic [31:0] live_addr[$];

  int errors = 0;
  int n_results = 0;
  int n_ok = 0;
  int n_merge_rel = 0;
  bit draining = 0;

  ffsa_pkg::req_t cur_req;
  logic s_axis_tready_q;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void table_reinit();
    for (int i = 0; i < ffsa_pkg::DESC_COUNT; i++) seg_tab[i] = '0;
    if (pred_size != 0) begin
      seg_tab[0].kind = ffsa_pkg::KIND_FREE;
      seg_tab[0].length = pred_size;
    end
    live_addr.delete();
  endfunction

  function automatic ffsa_pkg::res_t predict_request(ffsa_pkg::req_t r);
    ffsa_pkg::res_t o;
    int spare, best, hit;
    logic [15:0] st;
    o = '0;
    if (r.op == ffsa_pkg::OP_ALLOC) begin
      spare = -1;
      best = -1;
      if (r.size == 0) begin
        o.status = ffsa_pkg::ST_BAD;
        return o;
      end
      for (int i = ffsa_pkg::DESC_COUNT - 1; i >= 0; i--)
        if (seg_tab[i].kind == ffsa_pkg::KIND_UNUSED) spare = i;
      if (spare < 0) begin
        o.status = ffsa_pkg::ST_NO_DESC;
        return o;
      end
      for (int i = 0; i < ffsa_pkg::DESC_COUNT; i++)
        if (seg_tab[i].kind == ffsa_pkg::KIND_FREE && seg_tab[i].length >= r.size &&
            (best < 0 || seg_tab[i].offset < seg_tab[best].offset)) best = i;
      if (best < 0) begin
        o.status = ffsa_pkg::ST_NO_FIT;
        return o;
      end
      if (seg_tab[best].length != r.size) begin
        seg_tab[spare].kind = ffsa_pkg::KIND_FREE;
        seg_tab[spare].offset = seg_tab[best].offset + r.size;
        seg_tab[spare].length = seg_tab[best].length - r.size;
      end
      seg_tab[best].kind = ffsa_pkg::KIND_ALLOC;
      seg_tab[best].length = r.size;
      o.status = ffsa_pkg::ST_OK;
      o.addr = pred_base + 32'(seg_tab[best].offset);
      live_addr.push_back(o.addr);
    end else begin
      hit = -1;
      for (int i = 0; i < ffsa_pkg::DESC_COUNT; i++)
        if (hit < 0 && seg_tab[i].kind == ffsa_pkg::KIND_ALLOC &&
            pred_base + 32'(seg_tab[i].offset) == r.addr) hit = i;
      if (hit < 0) begin
        o.status = ffsa_pkg::ST_BAD;
        return o;
      end
      seg_tab[hit].kind = ffsa_pkg::KIND_FREE;
      st = seg_tab[hit].offset;
      for (int i = 0; i < ffsa_pkg::DESC_COUNT; i++)
        if (i != hit && seg_tab[i].kind == ffsa_pkg::KIND_FREE &&
            17'(seg_tab[i].offset) == 17'(st) + 17'(seg_tab[hit].length)) begin
          seg_tab[hit].length = seg_tab[hit].length + seg_tab[i].length;
          seg_tab[i] = '0;
          n_merge_rel++;
          break;
        end
      for (int i = 0; i < ffsa_pkg::DESC_COUNT; i++)
        if (i != hit && seg_tab[i].kind == ffsa_pkg::KIND_FREE &&
            17'(seg_tab[i].offset) + 17'(seg_tab[i].length) == 17'(st)) begin
          seg_tab[i].length = seg_tab[i].length + seg_tab[hit].length;
          seg_tab[hit] = '0;
          n_merge_rel++;
          break;
        end
      for (int k = 0; k < live_addr.size(); k++)
        if (live_addr[k] == r.addr) begin
          live_addr.delete(k);
          break;
        end
      o.status = ffsa_pkg::ST_OK;
    end
    return o;
  endfunction

  // driver: bursts with random gaps, prediction made at acceptance
  int gap = 0;
  int burst = 0;
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready_q) begin
        result_q.push_back(predict_request(cur_req));
        void'(req_q.pop_front());
      end
      if (!(s_axis_tvalid && !s_axis_tready_q)) begin
        if (gap > 0 || draining || req_q.size() == 0) begin
          if (gap > 0) gap--;
          s_axis_tvalid <= 0;
        end else begin
          s_axis_tvalid <= 1;
          s_axis_tdata <= {req_q[0].addr, req_q[0].size};
          s_axis_tuser <= req_q[0].op;
          cur_req = req_q[0];
          if (burst == 0) begin
            burst = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
          end else burst--;
        end
      end
    end
  end

  // handshake seen at the rising edge, used by the driver on the next falling edge
  always @(posedge clk) s_axis_tready_q <= s_axis_tready;

  // receiver stall pattern and result checker
  int stall_mode = 0;
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= ($urandom_range(0, 9) == 0);
      default: m_axis_tready <= ($urandom_range(0, 40) != 0) ? m_axis_tready : ~m_axis_tready;
    endcase
  end

  always @(posedge clk) begin
    ffsa_pkg::res_t exp_res;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (result_q.size() == 0) begin
        $error("result with nothing expected: status %0d addr %h", m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        exp_res = result_q.pop_front();
        if (exp_res.status == ffsa_pkg::ST_OK) n_ok++;
        if (m_axis_tuser !== exp_res.status) begin
          $error("status: expected %0d actual %0d", exp_res.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata !== exp_res.addr) begin
          $error("block_address: expected %h actual %h", exp_res.addr, m_axis_tdata);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    if (idx == ffsa_pkg::CFG_REGION_BASE) pred_base = val;
    else pred_size = val[15:0];
    table_reinit();
  endtask

  task automatic settle();
    // wait for all queued requests to be taken and every result to arrive
    while (req_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic ffsa_pkg::req_t mk(logic op, logic [15:0] sz, logic [31:0] a);
    ffsa_pkg::req_t r;
    r.op = op;
    r.size = sz;
    r.addr = a;
    return r;
  endfunction

  // queue one random request; most are well-formed allocs and releases of live blocks
  task automatic queue_random(input int max_sz);
    int p;
    logic [15:0] sz;
    p = $urandom_range(0, 99);
    sz = 16'($urandom_range(1, max_sz));
    if (p < 50) req_q.push_back(mk(ffsa_pkg::OP_ALLOC, sz, $urandom));
    else if (p < 85 && live_addr.size() != 0)
      req_q.push_back(mk(ffsa_pkg::OP_RELEASE, 16'($urandom),
                         live_addr[$urandom_range(0, live_addr.size() - 1)]));
    else if (p < 90) req_q.push_back(mk(ffsa_pkg::OP_ALLOC, 16'($urandom), $urandom));
    else if (p < 93) req_q.push_back(mk(ffsa_pkg::OP_ALLOC, 16'd0, $urandom));
    else req_q.push_back(mk(ffsa_pkg::OP_RELEASE, 16'($urandom),
                            pred_base + $urandom_range(0, 64)));
  endtask

  initial begin
    int n;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    pred_base = '0;
    pred_size = 16'd1024;
    table_reinit();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: releases are predicted at acceptance, so live_addr is filled later;
    // aim directed releases at known offsets instead
    req_q.push_back(mk(ffsa_pkg::OP_ALLOC, 16'd0, '0));
    req_q.push_back(mk(ffsa_pkg::OP_ALLOC, 16'hFFFF, '0));
    req_q.push_back(mk(ffsa_pkg::OP_ALLOC, 16'd100, '0));
    req_q.push_back(mk(ffsa_pkg::OP_ALLOC, 16'd200, '0));
    req_q.push_back(mk(ffsa_pkg::OP_ALLOC, 16'd300, '0));
    req_q.push_back(mk(ffsa_pkg::OP_RELEASE, 16'hFFFF, 32'd100));
    req_q.push_back(mk(ffsa_pkg::OP_RELEASE, '0, 32'd100));
    req_q.push_back(mk(ffsa_pkg::OP_RELEASE, '0, 32'd0));
    req_q.push_back(mk(ffsa_pkg::OP_RELEASE, '0, 32'hFFFF_FFFF));
    req_q.push_back(mk(ffsa_pkg::OP_ALLOC, 16'd424, '0));
    req_q.push_back(mk(ffsa_pkg::OP_ALLOC, 16'd1, '0));
    req_q.push_back(mk(ffsa_pkg::OP_RELEASE, '0, 32'd600));
    req_q.push_back(mk(ffsa_pkg::OP_RELEASE, '0, 32'd300));
    settle();

    // wrap of addresses near the top, one descriptor exhaustion run
    write_reg(ffsa_pkg::CFG_REGION_BASE, 32'hFFFF_FFF0);
    write_reg(ffsa_pkg::CFG_REGION_SIZE, 32'h0000_FFFF);
    for (int i = 0; i < 18; i++) req_q.push_back(mk(ffsa_pkg::OP_ALLOC, 16'd1, '0));
    req_q.push_back(mk(ffsa_pkg::OP_RELEASE, '0, 32'hFFFF_FFF0));
    req_q.push_back(mk(ffsa_pkg::OP_RELEASE, '0, 32'h0000_0000));
    req_q.push_back(mk(ffsa_pkg::OP_RELEASE, '0, 32'hFFFF_FFF1));
    settle();

    write_reg(ffsa_pkg::CFG_REGION_SIZE, 32'd1);
    req_q.push_back(mk(ffsa_pkg::OP_ALLOC, 16'd2, '0));
    req_q.push_back(mk(ffsa_pkg::OP_ALLOC, 16'd1, '0));
    req_q.push_back(mk(ffsa_pkg::OP_RELEASE, '0, 32'hFFFF_FFF0));
    settle();

    // random phases across several region settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(ffsa_pkg::CFG_REGION_BASE, 32'h0);
          write_reg(ffsa_pkg::CFG_REGION_SIZE, 32'd1024);
        end
        1: begin
          write_reg(ffsa_pkg::CFG_REGION_BASE, $urandom);
          write_reg(ffsa_pkg::CFG_REGION_SIZE, 32'd256);
        end
        2: begin
          write_reg(ffsa_pkg::CFG_REGION_BASE, 32'hFFFF_FF00);
          write_reg(ffsa_pkg::CFG_REGION_SIZE, 32'h0000_FFFF);
        end
        3: begin
          write_reg(ffsa_pkg::CFG_REGION_SIZE, 32'd64);
          write_reg(ffsa_pkg::CFG_REGION_BASE, $urandom);
        end
        4: begin
          write_reg(ffsa_pkg::CFG_REGION_BASE, 32'hFFFF_FFFF);
          write_reg(ffsa_pkg::CFG_REGION_SIZE, 32'd4096);
        end
        default: begin
          write_reg(ffsa_pkg::CFG_REGION_BASE, $urandom);
          write_reg(ffsa_pkg::CFG_REGION_SIZE, $urandom_range(1, 65535));
        end
      endcase
      n = 0;
      while (n < 100) begin
        // feed in small batches so releases can target blocks already predicted
        for (int k = 0; k < 4; k++) begin
          queue_random(ph == 2 ? 16384 : (pred_size > 4 ? int'(pred_size / 4) : 1));
          n++;
        end
        while (req_q.size() > 1) @(posedge clk);
        if (n == 48) settle();
      end
      settle();
    end

    draining = 1;
    repeat (100) @(posedge clk);
    $display("Covered %0d results, %0d ok, %0d merges on release, over several region settings.",
             n_results, n_ok, n_merge_rel);
    if (errors == 0 && result_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
